>>> rtl/core/sorted_insertion_store_assert.svh
// Assertion macros shared by the sorted insertion store RTL.
`ifndef SORTED_INSERTION_STORE_ASSERT_SVH
`define SORTED_INSERTION_STORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SIS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SIS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/sis_pkg.sv
// Shared types, codes and helper functions for the sorted insertion store.
package sis_pkg;

	localparam int VAL_W      = 16;
	localparam int IDX_W      = 8;
	localparam int OP_W       = 2;
	localparam int POS_W      = 9;
	localparam int FILL_W     = 9;
	localparam int ST_W       = 2;
	localparam int DEPTH_DEF  = 256;
	localparam int TREE_RADIX = 4;
	localparam int RADIX_LOG  = 2;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_READ   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

	// Broadcast to every cell in the row.
	typedef struct packed {
		logic              ins_en;
		logic              rd_en;
		logic [VAL_W-1:0]  new_value;
		logic [IDX_W-1:0]  read_index;
	} sis_cmd_t;

	typedef struct packed {
		logic [POS_W-1:0]  position;
		logic [VAL_W-1:0]  read_value;
		logic [FILL_W-1:0] fill_count;
		logic [ST_W-1:0]   status;
	} sis_rsp_t;

	// Registered levels needed to fold n leaves with radix-4 nodes.
	function automatic int tree_levels(input int n);
		return ($clog2(n) + 1) >> 1;
	endfunction

	// Node count at a given level of the fold tree.
	function automatic int tree_nodes(input int n, input int lvl);
		return (n + (1 << (RADIX_LOG * lvl)) - 1) >> (RADIX_LOG * lvl);
	endfunction

endpackage

>>> rtl/core/sis_cell.sv
// One storage cell of the sorted row: compare, shift and leaf result.
module sis_cell
	import sis_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	parameter int IDX   = 0,
	localparam int CW   = $clog2(DEPTH + 1),
	localparam int LW   = CW + VAL_W
) (
	input  logic             clk,
	input  sis_cmd_t         cmd,
	input  logic [CW-1:0]    count,
	input  logic             left_le,
	input  logic [VAL_W-1:0] left_value,
	input  logic             right_le,
	output logic             le,
	output logic [VAL_W-1:0] value,
	output logic [LW-1:0]    leaf
);

	localparam bit RD_REACH = IDX < (1 << IDX_W);

	logic [VAL_W-1:0] value_q;
	logic             occ;
	logic             rd_hit;
	logic [CW-1:0]    pos_part;
	logic [VAL_W-1:0] val_part;

	assign occ   = CW'(IDX) < count;
	assign le    = occ && (value_q <= cmd.new_value);
	assign value = value_q;

	assign rd_hit   = RD_REACH && occ && (IDX_W'(IDX) == cmd.read_index);
	// The boundary between "<= new" and "> new" marks the insert slot.
	assign pos_part = (cmd.ins_en && le && !right_le) ? CW'(IDX + 1) : '0;
	assign val_part = (cmd.rd_en && rd_hit) ? value_q : '0;
	assign leaf     = {pos_part, val_part};

	// Hold when at or below the new value, else take the new value or shift up.
	always_ff @(posedge clk) begin
		if (cmd.ins_en && !le) begin
			value_q <= left_le ? cmd.new_value : left_value;
		end
	end

endmodule

>>> rtl/core/sis_or_tree.sv
// Registered radix-4 OR fold that gathers one-hot leaf results from the row.
module sis_or_tree
	import sis_pkg::*;
#(
	parameter int N      = DEPTH_DEF,
	parameter int W      = VAL_W,
	localparam int LVLS  = tree_levels(N)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [N-1:0][W-1:0] leaves,
	output logic                root_valid,
	output logic [W-1:0]        root
);

	logic [W-1:0]      lvl [0:LVLS][0:N-1];
	logic [LVLS-1:0]   vld_q;

	for (genvar n = 0; n < N; n++) begin : g_l0
		assign lvl[0][n] = leaves[n];
	end

	for (genvar k = 1; k <= LVLS; k++) begin : g_lvl
		localparam int PREV = tree_nodes(N, k - 1);
		localparam int CUR  = tree_nodes(N, k);
		for (genvar n = 0; n < N; n++) begin : g_node
			if (n < CUR) begin : g_live
				logic [TREE_RADIX-1:0][W-1:0] part;
				logic [W-1:0]                 node_q;
				for (genvar j = 0; j < TREE_RADIX; j++) begin : g_in
					if (TREE_RADIX * n + j < PREV) begin : g_used
						assign part[j] = lvl[k-1][TREE_RADIX * n + j];
					end else begin : g_pad
						assign part[j] = '0;
					end
				end
				always_ff @(posedge clk) begin
					node_q <= part[0] | part[1] | part[2] | part[3];
				end
				assign lvl[k][n] = node_q;
			end else begin : g_dead
				assign lvl[k][n] = '0;
			end
		end
	end

	// Track the transfer through the levels.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q[0] <= in_valid;
			for (int i = 1; i < LVLS; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	assign root_valid = vld_q[LVLS-1];
	assign root       = lvl[LVLS][0];

endmodule

>>> rtl/core/sorted_insertion_store.sv
// Sorted insertion store: a row of DEPTH cells kept in ascending order.
// One item is in flight at a time: its leaf results pass through the registered levels of the
// OR fold, and intake reopens only after the OR fold lands its result. A finished result may
// wait while the next is taken.
// Reset (arst_n low, asynchronous) empties the store and drops any pending transfer.
// Cell contents are not cleared; only entries below the count are ever read.
`include "sorted_insertion_store_assert.svh"

module sorted_insertion_store
	import sis_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// Request channel.
	input  logic              req_valid,
	output logic              req_stall,
	input  logic [OP_W-1:0]   operation,
	input  logic [VAL_W-1:0]  new_value,
	input  logic [IDX_W-1:0]  read_index,
	// Response channel.
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [POS_W-1:0]  position,
	output logic [VAL_W-1:0]  read_value,
	output logic [FILL_W-1:0] fill_count,
	output logic [ST_W-1:0]   status
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = CW + VAL_W;

	// Control state.
	logic          busy_q;
	logic          rsp_valid_q;
	logic          hold_valid_q;
	logic [CW-1:0] count_q;

	// Result payload held for the response channel.
	logic     side_q;
	sis_rsp_t meta_q;
	sis_rsp_t rsp_q;
	sis_rsp_t hold_q;

	logic          accept;
	logic          full;
	logic          drain;
	logic [CW-1:0] count_d;
	sis_cmd_t      cmd;
	sis_rsp_t      meta_d;
	sis_rsp_t      fresh;

	logic [DEPTH-1:0]          le;
	logic [VAL_W-1:0]          cval [DEPTH];
	logic [DEPTH-1:0][LW-1:0]  leaf;
	logic                      root_valid;
	logic [LW-1:0]             root;

	// Take one item at a time; a result parked in the hold slot blocks intake.
	assign req_stall = busy_q || hold_valid_q;
	assign accept    = req_valid && !req_stall;
	assign full      = count_q == CW'(DEPTH);
	assign drain     = rsp_valid_q && !rsp_stall;

	// Broadcast to the row; enables are live only on the transfer edge.
	always_comb begin
		cmd.ins_en     = accept && (operation == OP_INSERT) && !full;
		cmd.rd_en      = accept && (operation == OP_READ);
		cmd.new_value  = new_value;
		cmd.read_index = read_index;
	end

	// Next count and the fields known at intake.
	always_comb begin
		count_d          = count_q;
		meta_d.position  = '0;
		meta_d.read_value = '0;
		meta_d.status    = ST_OK;
		case (operation)
			OP_INSERT: begin
				if (full) begin
					meta_d.status = ST_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			OP_READ: begin
				meta_d.position = POS_W'(read_index);
				if (CW'(read_index) >= count_q || read_index >= (1 << CW)) begin
					meta_d.status = ST_RANGE;
				end
			end
			OP_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
		meta_d.fill_count = FILL_W'(count_d);
	end

	// Row of cells; each compares against the new value and shifts from its left.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic             left_le;
		logic [VAL_W-1:0] left_value;
		logic             right_le;
		if (i == 0) begin : g_head
			assign left_le    = 1'b1;
			assign left_value = new_value;
		end else begin : g_body
			assign left_le    = le[i-1];
			assign left_value = cval[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_le = 1'b0;
		end else begin : g_mid
			assign right_le = le[i+1];
		end
		sis_cell #(
			.DEPTH (DEPTH),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.left_le    (left_le),
			.left_value (left_value),
			.right_le   (right_le),
			.le         (le[i]),
			.value      (cval[i]),
			.leaf       (leaf[i])
		);
	end

	// Gather the insert slot and the read element; at most one cell drives each.
	sis_or_tree #(
		.N (DEPTH),
		.W (LW)
	) u_tree (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (accept),
		.leaves     (leaf),
		.root_valid (root_valid),
		.root       (root)
	);

	always_comb begin
		fresh            = meta_q;
		fresh.position   = meta_q.position | POS_W'(root[LW-1:VAL_W]);
		fresh.read_value = root[VAL_W-1:0];
	end

	// Count and handshake control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			busy_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
				busy_q  <= 1'b1;
			end else if (root_valid) begin
				busy_q <= 1'b0;
			end
			if (root_valid) begin
				if (!rsp_valid_q || drain) begin
					rsp_valid_q <= 1'b1;
				end else begin
					hold_valid_q <= 1'b1;
				end
			end else if (drain) begin
				rsp_valid_q  <= hold_valid_q;
				hold_valid_q <= 1'b0;
			end
		end
	end

	// Payload: capture intake fields, then land the folded result.
	always_ff @(posedge clk) begin
		if (accept) begin
			meta_q <= meta_d;
			side_q <= operation == OP_READ;
		end
		if (root_valid) begin
			if (!rsp_valid_q || drain) begin
				rsp_q <= fresh;
			end else begin
				hold_q <= fresh;
			end
		end else if (drain && hold_valid_q) begin
			rsp_q <= hold_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign position   = rsp_q.position;
	assign read_value = rsp_q.read_value;
	assign fill_count = rsp_q.fill_count;
	assign status     = rsp_q.status;

	`SIS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "element count beyond depth")
	`SIS_ASSERT_NOW(a_root_in_flight, root_valid, busy_q, "fold result with no item in flight")
	`SIS_ASSERT_NOW(a_hold_behind_out, hold_valid_q, rsp_valid_q && !root_valid,
		"hold slot used while output empty or fold still active")
	`SIS_ASSERT_NEXT(a_insert_grows, cmd.ins_en, count_q == $past(count_q) + CW'(1),
		"accepted insert did not grow the store")
	`SIS_ASSERT_NOW(a_read_range, root_valid && side_q && meta_q.status == ST_RANGE,
		root[VAL_W-1:0] == '0, "out-of-range read picked up an element")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the sorted insertion store: directed and random command streams.
module testbench;
	import sis_pkg::*;

	// Operation code 3 is not decoded; the block must take it and leave the store alone.
	localparam logic [OP_W-1:0] OP_IDLE = 2'd3;

	localparam int STORE_DEPTH      = DEPTH_DEF;
	localparam int COMMAND_TARGET   = 1350;
	localparam int HOLDOFF_AT       = 300;   // transfers taken before the long reply hold-off
	localparam int HOLDOFF_CYCLES   = 400;
	localparam int IDLE_LIMIT       = 4000;  // cycles with no transfer on either side
	localparam int SETTLE_CYCLES    = 20;    // settle time after the last reply before the verdict
	localparam int SHOWN_MISMATCHES = 10;

	typedef struct {
		logic [OP_W-1:0]  op;
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] index;
		bit               drain_first;  // wait until every reply is back before offering
	} store_command_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_HALF,
		STALL_HEAVY,
		STALL_COMB
	} stall_mode_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              req_valid  = 1'b0;
	logic              req_stall;
	logic [OP_W-1:0]   operation  = OP_CLEAR;
	logic [VAL_W-1:0]  new_value  = '0;
	logic [IDX_W-1:0]  read_index = '0;
	logic              rsp_valid;
	logic              rsp_stall  = 1'b0;
	logic [POS_W-1:0]  position;
	logic [VAL_W-1:0]  read_value;
	logic [FILL_W-1:0] fill_count;
	logic [ST_W-1:0]   status;

	sorted_insertion_store #(.DEPTH(STORE_DEPTH)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.operation  (operation),
		.new_value  (new_value),
		.read_index (read_index),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.position   (position),
		.read_value (read_value),
		.fill_count (fill_count),
		.status     (status)
	);

	always #6 clk = ~clk;

	// Commands waiting to be offered, and replies owed by the block in transfer order.
	store_command_t queued_commands[$];
	sis_rsp_t       due_replies[$];

	// Transfer counters bumped with nonblocking writes so the other processes see stable values.
	int unsigned commands_taken = 0;
	int unsigned replies_taken  = 0;
	int unsigned mismatch_count = 0;

	// ------------------------------------------------------------------
	// Predictor: our own copy of the sorted store and its fill count.
	// ------------------------------------------------------------------
	logic [VAL_W-1:0] store_values [STORE_DEPTH];
	int unsigned      store_count = 0;

	// Apply one accepted command to the shadow store and return the reply it owes.
	function automatic sis_rsp_t apply_command(input logic [OP_W-1:0] op,
			input logic [VAL_W-1:0] value, input logic [IDX_W-1:0] index);
		sis_rsp_t    reply;
		int unsigned slot;
		int unsigned k;
		reply = '0;
		slot = 0;
		case (op)
			OP_INSERT: begin
				if (store_count >= STORE_DEPTH) begin
					// Full store: reject, leave contents untouched.
					reply.status = ST_FULL;
				end else begin
					// Land after every element <= value, so equal keys keep arrival order.
					while (slot < store_count && store_values[slot] <= value)
						slot++;
					for (k = store_count; k > slot; k--)
						store_values[k] = store_values[k - 1];
					store_values[slot] = value;
					store_count++;
					reply.position = POS_W'(slot);
				end
			end
			OP_READ: begin
				reply.position = POS_W'(index);
				if (index < store_count)
					reply.read_value = store_values[index];
				else
					reply.status = ST_RANGE;
			end
			OP_CLEAR: begin
				store_count = 0;
			end
			default: ;
		endcase
		reply.fill_count = FILL_W'(store_count);
		return reply;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus generation. planned_count tracks the fill level the queue will
	// produce, so reads can be aimed mostly inside the stored range.
	// ------------------------------------------------------------------
	int unsigned planned_count    = 0;
	int unsigned planned_commands = 0;

	task automatic queue_command(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
			input logic [IDX_W-1:0] index, input bit drain_first = 1'b0);
		store_command_t cmd;
		cmd.op = op;
		cmd.value = value;
		cmd.index = index;
		cmd.drain_first = drain_first;
		queued_commands.push_back(cmd);
		case (op)
			OP_INSERT: if (planned_count < STORE_DEPTH) planned_count++;
			OP_CLEAR:  planned_count = 0;
			default: ;
		endcase
		// Every queued command is one transfer, ignored codes included.
		planned_commands++;
	endtask

	function automatic logic [VAL_W-1:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 5)
			return VAL_W'($urandom_range(0, 65535));
		// Crowd a few small keys so runs of equal values build up.
		if (roll < 8)
			return VAL_W'($urandom_range(0, 15));
		if (roll == 8)
			return VAL_W'(0);
		return {VAL_W{1'b1}};
	endfunction

	function automatic logic [IDX_W-1:0] pick_read_index();
		if (planned_count > 0 && $urandom_range(0, 4) != 0)
			return IDX_W'($urandom_range(0, planned_count - 1));
		return IDX_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [IDX_W-1:0] any_index();
		return IDX_W'($urandom_range(0, 255));
	endfunction

	// Mixed traffic: mostly inserts and reads, now and then an idle code or a clear.
	task automatic queue_random(input bit drain_first);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			queue_command(OP_INSERT, pick_value(), any_index(), drain_first);
		else if (roll < 90)
			queue_command(OP_READ, pick_value(), pick_read_index(), drain_first);
		else if (roll < 96)
			queue_command(OP_IDLE, pick_value(), any_index(), drain_first);
		else
			queue_command(OP_CLEAR, pick_value(), any_index(), drain_first);
	endtask

	// Grow the store to full without clears, then push past it and read the ends.
	task automatic fill_store(input bit drain_first);
		bit first;
		first = drain_first;
		while (planned_count < STORE_DEPTH) begin
			if ($urandom_range(0, 4) == 0)
				queue_command(OP_READ, pick_value(), pick_read_index(), first);
			else
				queue_command(OP_INSERT, pick_value(), any_index(), first);
			first = 1'b0;
		end
		repeat (3)
			queue_command(OP_INSERT, pick_value(), any_index());
		queue_command(OP_READ, pick_value(), 8'hFF);
		queue_command(OP_READ, pick_value(), 8'h00);
		queue_command(OP_READ, pick_value(), any_index());
	endtask

	// ------------------------------------------------------------------
	// Sender: offer queued commands in bursts separated by random gaps.
	// ------------------------------------------------------------------
	int unsigned burst_left = 1;
	int unsigned gap_left   = 0;

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return 0;
		if (roll < 9)
			return $urandom_range(1, 4);
		return $urandom_range(5, 15);
	endfunction

	always @(posedge clk) begin : driver
		store_command_t next_cmd;
		bit             taken;
		if (arst_n) begin
			taken = req_valid && !req_stall;
			if (taken) begin
				// Predict at the transfer, from the payload the block just took.
				due_replies.push_back(apply_command(operation, new_value, read_index));
				commands_taken <= commands_taken + 1;
			end
			// Payload may only move when nothing is offered or the offer just went through.
			if (!req_valid || taken) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_valid <= 1'b0;
				end else if (queued_commands.size() > 0 && (!queued_commands[0].drain_first
						|| (!taken && commands_taken == replies_taken))) begin
					next_cmd = queued_commands.pop_front();
					req_valid <= 1'b1;
					operation <= next_cmd.op;
					new_value <= next_cmd.value;
					read_index <= next_cmd.index;
					if (burst_left > 1) begin
						burst_left <= burst_left - 1;
					end else begin
						burst_left <= $urandom_range(1, 48);
						gap_left <= pick_gap();
					end
				end else begin
					// Hold off: queue empty, or waiting for the block to drain.
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall in random modes, plus one long hold-off that backs
	// the block up into its request side while the sender keeps offering.
	// ------------------------------------------------------------------
	stall_mode_t stall_mode    = STALL_NONE;
	int unsigned mode_left     = 0;
	int unsigned holdoff_left  = 0;
	bit          holdoff_done  = 1'b0;
	logic [1:0]  pattern_phase = '0;

	always @(posedge clk) begin : receiver
		bit hold;
		hold = 1'b0;
		if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
			hold = 1'b1;
		end else if (!holdoff_done && commands_taken >= HOLDOFF_AT) begin
			holdoff_done <= 1'b1;
			holdoff_left <= HOLDOFF_CYCLES;
			hold = 1'b1;
		end else begin
			case (stall_mode)
				STALL_NONE:  hold = 1'b0;
				STALL_HALF:  hold = $urandom_range(0, 1) != 0;
				STALL_HEAVY: hold = $urandom_range(0, 4) != 0;
				STALL_COMB:  hold = pattern_phase == 2'd0;
				default:     hold = 1'b0;
			endcase
		end
		pattern_phase <= pattern_phase + 1'b1;
		// Switch modes every so often so stalls land on every phase of the work.
		if (mode_left > 0) begin
			mode_left <= mode_left - 1;
		end else begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			mode_left <= $urandom_range(8, 120);
		end
		rsp_stall <= hold;
	end

	// ------------------------------------------------------------------
	// Monitor: check each reply transfer against the oldest owed reply.
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string what, input sis_rsp_t want,
			input sis_rsp_t got);
		mismatch_count++;
		if (mismatch_count <= SHOWN_MISMATCHES)
			$display("mismatch (%s) at %0t: expected pos=%0d val=%h fill=%0d st=%0d,",
				what, $time, want.position, want.read_value, want.fill_count, want.status,
				" got pos=%0d val=%h fill=%0d st=%0d",
				got.position, got.read_value, got.fill_count, got.status);
	endtask

	always @(posedge clk) begin : monitor
		sis_rsp_t got;
		sis_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got.position = position;
			got.read_value = read_value;
			got.fill_count = fill_count;
			got.status = status;
			replies_taken <= replies_taken + 1;
			if (due_replies.size() == 0) begin
				report_mismatch("reply with nothing owed", '0, got);
			end else begin
				want = due_replies.pop_front();
				if (got.position !== want.position || got.read_value !== want.read_value
						|| got.fill_count !== want.fill_count || got.status !== want.status)
					report_mismatch("field differs", want, got);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if neither side transfers for too long.
	// ------------------------------------------------------------------
	int unsigned idle_cycles = 0;

	always @(posedge clk) begin : watchdog
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("** sorted_insertion_store: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Build the whole command stream, release reset, wait for the drain.
	// ------------------------------------------------------------------
	initial begin : stimulus
		int unsigned seg_len;
		bit          seg_drain;

		// Empty store: clear, then reads at both ends of the index range fall out of range.
		queue_command(OP_CLEAR, 16'h0000, 8'h00);
		queue_command(OP_READ, 16'hFFFF, 8'h00);
		queue_command(OP_READ, 16'h0000, 8'hFF);
		// Extremes and ties: a repeated key lands after its equal.
		queue_command(OP_INSERT, 16'h0000, 8'hFF);
		queue_command(OP_INSERT, 16'hFFFF, 8'h00);
		queue_command(OP_INSERT, 16'h0000, 8'h00);
		queue_command(OP_INSERT, 16'hFFFF, 8'hFF);
		queue_command(OP_INSERT, 16'h8000, 8'h55);
		queue_command(OP_INSERT, 16'h5555, 8'hAA);
		queue_command(OP_INSERT, 16'hAAAA, 8'h55);
		// Walk every stored element, then one past the end.
		for (int i = 0; i < 8; i++)
			queue_command(OP_READ, 16'h0000, IDX_W'(i));
		// Unused code with all-ones and all-zeros payloads.
		queue_command(OP_IDLE, 16'hFFFF, 8'hFF);
		queue_command(OP_IDLE, 16'h0000, 8'h00);
		queue_command(OP_READ, 16'h0000, 8'h06);
		queue_command(OP_CLEAR, 16'hFFFF, 8'hFF);
		queue_command(OP_READ, 16'h0000, 8'h00);
		queue_command(OP_INSERT, 16'h1234, 8'h00);

		// Drain, then run the store up to full and past it.
		fill_store(1'b1);
		queue_command(OP_CLEAR, pick_value(), any_index(), 1'b1);

		while (planned_commands < COMMAND_TARGET) begin
			seg_drain = $urandom_range(0, 3) == 0;
			if ($urandom_range(0, 5) == 0) begin
				fill_store(seg_drain);
			end else begin
				seg_len = $urandom_range(20, 80);
				for (int i = 0; i < seg_len; i++)
					queue_random(seg_drain && i == 0);
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every command has been taken and every owed reply has come back.
		while (queued_commands.size() != 0 || req_valid || commands_taken != replies_taken)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && due_replies.size() == 0) begin
			$display("** sorted_insertion_store: PASSED **");
		end else begin
			$display("** sorted_insertion_store: FAILED **");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/sis_pkg.sv
rtl/core/sis_cell.sv
rtl/core/sis_or_tree.sv
rtl/core/sorted_insertion_store.sv
tb/testbench.sv
